### hdl/hcspr_pkg.sv
package hcspr_pkg;
   localparam int NODE_BITS = 5;
   localparam int NODES = 32;
   localparam int COST_BITS = 8;
   localparam int DIST_BITS = 13;
   localparam int EDGE_BITS = 2 * NODE_BITS;
   localparam int MAX_RESULTS = 31;
   localparam logic [DIST_BITS-1:0] TOTAL_MAX = 13'd8191;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_ROUTE = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;
   localparam logic MODE_ADD = 1'b0;

   typedef struct packed {
      logic                 present;
      logic [COST_BITS-1:0] cost;
   } edge_type;
endpackage

### hdl/hop_count_shortest_path_router.sv
// Channel  | handshake               | payload
// request  | start in, busy out      | req_mode req_src_node req_dst_node req_link_count req_symmetric
// response | rsp_valid out (1 cycle) | rsp_status rsp_hop_from rsp_hop_to rsp_hop_links
//          |                         | rsp_total_links rsp_last
// config   | csr_we in               | csr_wdata (cache_enable)
//
// After reset a clearing pass over the edge memory marks every edge absent; busy is high
// meanwhile. An add reads and checks the edge, then writes it if absent; if so and req_symmetric
// is set, it does the same for the reverse edge. A query that runs the search scans the distance
// memory and reads the edge row of each selected node; each hop of the result then passes through
// the states S_P_RD, S_P_EDGE and S_P_OUT. A cached query skips the search.
// The response strobe cannot be held off; busy covers the whole item.
module hop_count_shortest_path_router
   import hcspr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [NODE_BITS-1:0] req_src_node,
   input  logic [NODE_BITS-1:0] req_dst_node,
   input  logic [COST_BITS-1:0] req_link_count,
   input  logic                 req_symmetric,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [NODE_BITS-1:0] rsp_hop_from,
   output logic [NODE_BITS-1:0] rsp_hop_to,
   output logic [COST_BITS-1:0] rsp_hop_links,
   output logic [DIST_BITS-1:0] rsp_total_links,
   output logic                 rsp_last
);
   localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_A_RD = 5'd2, S_A_CHK = 5'd3,
      S_R_RD = 5'd4, S_R_CHK = 5'd5, S_INIT = 5'd6, S_SCAN = 5'd7, S_SCAN_W = 5'd8,
      S_SEL = 5'd9, S_REL_RD = 5'd10, S_REL = 5'd11, S_Q_RD = 5'd12, S_Q_CHK = 5'd13,
      S_P_RD = 5'd14, S_P_EDGE = 5'd15, S_P_OUT = 5'd16;

   edge_type             edge_mem [1024];
   logic [DIST_BITS:0]   dist_mem [NODES];
   logic [NODE_BITS-1:0] pred_mem [NODES];

   logic [4:0]           state_ff, state_in;
   logic [EDGE_BITS:0]   cnt_ff, cnt_in;
   logic                 sym_ff;
   logic [NODE_BITS-1:0] src_ff, dst_ff;
   logic [COST_BITS-1:0] links_ff;
   logic [NODES-1:0]     fin_ff, fin_in;
   logic                 cen_ff, cvalid_ff, cvalid_in;
   logic [NODE_BITS-1:0] csrc_ff, csrc_in;
   logic [DIST_BITS:0]   best_ff, best_in;
   logic                 found_ff, found_in;
   logic [NODE_BITS-1:0] v_ff, v_in, pv_ff, pv_in;
   logic [DIST_BITS:0]   dv_ff, dv_in;
   logic [DIST_BITS-1:0] tot_ff, tot_in;
   logic [4:0]           k_ff, k_in;
   logic                 accept;

   logic                 e_we;
   logic [EDGE_BITS-1:0] e_wa, e_ra;
   edge_type             e_wd, e_rd;
   logic                 d_we;
   logic [NODE_BITS-1:0] d_wa, d_ra, p_wa, p_ra;
   logic [DIST_BITS:0]   d_wd, d_rd;
   logic                 p_we;
   logic [NODE_BITS-1:0] p_wd, p_rd;

   logic                 o_v, o_last;
   logic [1:0]           o_st;
   logic [NODE_BITS-1:0] o_from, o_to;
   logic [COST_BITS-1:0] o_links;
   logic [DIST_BITS-1:0] o_tot;
   logic [DIST_BITS:0]   nd;
   logic [NODE_BITS-1:0] ci;
   logic [DIST_BITS:0]   tsum;

   always_ff @(posedge clock) begin
      if (e_we) edge_mem[e_wa] <= e_wd;
      e_rd <= edge_mem[e_ra];
      if (d_we) dist_mem[d_wa] <= d_wd;
      d_rd <= dist_mem[d_ra];
      if (p_we) pred_mem[p_wa] <= p_wd;
      p_rd <= pred_mem[p_ra];
   end

   assign accept = start && !busy;
   assign ci = cnt_ff[NODE_BITS-1:0];
   assign nd = dv_ff + {{(DIST_BITS+1-COST_BITS){1'b0}}, e_rd.cost};
   assign tsum = {1'b0, tot_ff} + {{(DIST_BITS+1-COST_BITS){1'b0}}, e_rd.cost};

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; fin_in = fin_ff; cvalid_in = cvalid_ff;
      csrc_in = csrc_ff; best_in = best_ff; found_in = found_ff; v_in = v_ff;
      pv_in = pv_ff; dv_in = dv_ff; tot_in = tot_ff; k_in = k_ff;
      e_we = 1'b0; e_wa = {src_ff, dst_ff}; e_wd = '{present: 1'b1, cost: links_ff};
      e_ra = {src_ff, dst_ff};
      d_we = 1'b0; d_wa = ci; d_wd = '1; d_ra = ci;
      p_we = 1'b0; p_wa = ci; p_wd = '0; p_ra = v_ff;
      o_v = 1'b0; o_st = ST_OK; o_from = '0; o_to = '0; o_links = '0; o_tot = '0;
      o_last = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            e_we = 1'b1; e_wa = cnt_ff[EDGE_BITS-1:0]; e_wd = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[EDGE_BITS-1:0] == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ADD) state_in = S_A_RD;
               else state_in = S_Q_RD;
            end
         end
         S_A_RD: state_in = S_A_CHK;
         S_A_CHK: begin
            if (e_rd.present) begin
               o_v = 1'b1; o_st = ST_DUPLICATE; state_in = S_IDLE;
            end else begin
               e_we = 1'b1; cvalid_in = 1'b0;
               if (sym_ff) state_in = S_R_RD;
               else begin
                  o_v = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_R_RD: begin
            e_ra = {dst_ff, src_ff}; state_in = S_R_CHK;
         end
         S_R_CHK: begin
            o_v = 1'b1; state_in = S_IDLE;
            if (e_rd.present) o_st = ST_DUPLICATE;
            else begin
               e_we = 1'b1; e_wa = {dst_ff, src_ff};
            end
         end
         S_Q_RD: begin
            if (cen_ff && cvalid_ff && csrc_ff == src_ff) state_in = S_Q_CHK;
            else begin
               cnt_in = '0; state_in = S_INIT;
            end
            e_ra = {src_ff, src_ff};
            d_ra = dst_ff;
         end
         S_INIT: begin
            d_we = 1'b1; p_we = 1'b1;
            if (ci == src_ff) d_wd = '0;
            fin_in = '0; cnt_in = cnt_ff + 1'b1;
            if (ci == NODE_BITS'(NODES - 1)) begin
               cnt_in = '0; best_in = '1; found_in = 1'b0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            d_ra = ci; cnt_in = cnt_ff + 1'b1; state_in = S_SCAN_W;
         end
         S_SCAN_W: begin
            if (!fin_ff[v_ff] && d_rd < best_ff) begin
               best_in = d_rd; found_in = 1'b1; pv_in = v_ff;
            end
            if (cnt_ff[NODE_BITS]) state_in = S_SEL;
            else begin
               d_ra = ci; cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SEL: begin
            if (!found_ff || fin_ff == '1) begin
               e_ra = {src_ff, src_ff}; d_ra = dst_ff; state_in = S_Q_CHK;
               if (!found_ff) state_in = S_Q_CHK;
            end else begin
               fin_in = fin_ff | (NODES'(1) << pv_ff);
               dv_in = best_ff; cnt_in = '0; state_in = S_REL_RD;
            end
         end
         S_REL_RD: begin
            e_ra = {pv_ff, ci}; d_ra = ci; state_in = S_REL;
         end
         S_REL: begin
            if (e_rd.present && nd < d_rd) begin
               d_we = 1'b1; d_wd = nd; p_we = 1'b1; p_wd = pv_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (ci == NODE_BITS'(NODES - 1)) begin
               cnt_in = '0; best_in = '1; found_in = 1'b0;
               state_in = (fin_ff == '1) ? S_SEL : S_SCAN;
               if (fin_ff == '1) found_in = 1'b0;
            end else state_in = S_REL_RD;
         end
         S_Q_CHK: begin
            csrc_in = src_ff; cvalid_in = cen_ff; o_v = 1'b1; state_in = S_IDLE;
            if (src_ff == dst_ff) begin
               if (!e_rd.present) o_st = ST_NO_ROUTE;
               else begin
                  o_from = src_ff; o_to = src_ff; o_links = e_rd.cost;
                  o_tot = {{(DIST_BITS-COST_BITS){1'b0}}, e_rd.cost};
               end
            end else if (d_rd == '1) o_st = ST_NO_ROUTE;
            else begin
               o_v = 1'b0; v_in = dst_ff; tot_in = '0; k_in = '0; state_in = S_P_RD;
            end
         end
         S_P_RD: begin
            p_ra = v_ff; state_in = S_P_EDGE;
         end
         S_P_EDGE: begin
            pv_in = p_rd; e_ra = {p_rd, v_ff}; state_in = S_P_OUT;
         end
         S_P_OUT: begin
            o_v = 1'b1; o_from = pv_ff; o_to = v_ff;
            o_links = e_rd.present ? e_rd.cost : '0;
            if (!e_rd.present) tot_in = tot_ff;
            else if (tsum > {1'b0, TOTAL_MAX}) tot_in = TOTAL_MAX;
            else tot_in = tsum[DIST_BITS-1:0];
            o_tot = tot_in;
            o_last = (pv_ff == src_ff) || (k_ff == 5'(MAX_RESULTS - 1));
            k_in = k_ff + 1'b1; v_in = pv_ff;
            state_in = o_last ? S_IDLE : S_P_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0; fin_ff <= '0; cen_ff <= 1'b0;
         cvalid_ff <= 1'b0; csrc_ff <= '0; rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; fin_ff <= fin_in;
         cvalid_ff <= cvalid_in; csrc_ff <= csrc_in; rsp_valid <= o_v;
         if (csr_we) cen_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && accept) begin
         src_ff <= req_src_node; dst_ff <= req_dst_node;
         links_ff <= req_link_count; sym_ff <= req_symmetric;
      end
      best_ff <= best_in; found_ff <= found_in; pv_ff <= pv_in; dv_ff <= dv_in;
      tot_ff <= tot_in; k_ff <= k_in;
      v_ff <= (state_ff == S_SCAN || state_ff == S_SCAN_W) ? ci : v_in;
      rsp_status <= o_st; rsp_hop_from <= o_from; rsp_hop_to <= o_to;
      rsp_hop_links <= o_links; rsp_total_links <= o_tot; rsp_last <= o_last;
   end

   assign busy = (state_ff != S_IDLE) || rsp_valid;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      o_v |-> busy) else $error("response outside an item");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> state_ff != S_IDLE) else $error("lost hops");
   a_add_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DUPLICATE) |-> rsp_total_links == '0)
      else $error("duplicate with payload");
endmodule

### dv/testbench.sv
`default_nettype none

module testbench
   import hcspr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int unsigned UNREACHED = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]           status;
      logic [NODE_BITS-1:0] hop_from;
      logic [NODE_BITS-1:0] hop_to;
      logic [COST_BITS-1:0] hop_links;
      logic [DIST_BITS-1:0] total_links;
      logic                 last;
   } hop_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_mode = MODE_ADD;
   logic [NODE_BITS-1:0] req_src_node = '0;
   logic [NODE_BITS-1:0] req_dst_node = '0;
   logic [COST_BITS-1:0] req_link_count = '0;
   logic                 req_symmetric = 1'b0;
   logic                 csr_we = 1'b0;
   logic                 csr_wdata = 1'b0;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [NODE_BITS-1:0] rsp_hop_from;
   logic [NODE_BITS-1:0] rsp_hop_to;
   logic [COST_BITS-1:0] rsp_hop_links;
   logic [DIST_BITS-1:0] rsp_total_links;
   logic                 rsp_last;

   hop_count_shortest_path_router dut (.*);

   always #5 clock = ~clock;

   // Model of the router state.
   logic                 link_present [NODES*NODES];
   logic [COST_BITS-1:0] link_cost [NODES*NODES];
   int unsigned          path_dist [NODES];
   logic [NODE_BITS-1:0] path_pred [NODES];
   logic [NODE_BITS-1:0] cached_src;
   logic                 cache_held;
   logic                 cache_on;

   hop_beat_type pending_hops[$];
   int           mismatches;
   int           cycles;
   logic         steady;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      hop_beat_type got;
      hop_beat_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_hop_from, rsp_hop_to, rsp_hop_links, rsp_total_links,
                 rsp_last};
         if (pending_hops.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected beat: expected none, actual %p", got);
         end else begin
            want = pending_hops.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   function automatic logic add_link(int a, int b, logic [COST_BITS-1:0] cost);
      if (link_present[a*NODES+b])
         return 1'b0;
      link_present[a*NODES+b] = 1'b1;
      link_cost[a*NODES+b] = cost;
      cache_held = 1'b0;
      return 1'b1;
   endfunction

   function automatic void search_from(int src);
      logic [NODES-1:0] done;
      int unsigned      best;
      int unsigned      nd;
      int               v;
      logic             found;
      done = '0;
      for (int i = 0; i < NODES; i++) begin
         path_dist[i] = UNREACHED;
         path_pred[i] = '0;
      end
      path_dist[src] = 0;
      for (int n = 0; n < NODES; n++) begin
         best = UNREACHED;
         v = 0;
         found = 1'b0;
         for (int i = 0; i < NODES; i++)
            if (!done[i] && path_dist[i] < best) begin
               best = path_dist[i];
               v = i;
               found = 1'b1;
            end
         if (!found)
            break;
         done[v] = 1'b1;
         for (int i = 0; i < NODES; i++)
            if (link_present[v*NODES+i]) begin
               nd = path_dist[v] + link_cost[v*NODES+i];
               if (nd < path_dist[i]) begin
                  path_dist[i] = nd;
                  path_pred[i] = v[NODE_BITS-1:0];
               end
            end
      end
   endfunction

   function automatic void predict_route(logic mode, int src, int dst,
                                         logic [COST_BITS-1:0] links, logic sym);
      hop_beat_type         hop;
      logic [1:0]           st;
      int                   v;
      int                   p;
      int                   k;
      int unsigned          total;
      logic [COST_BITS-1:0] c;
      hop = '0;
      hop.last = 1'b1;
      if (mode == MODE_ADD) begin
         st = ST_OK;
         if (!add_link(src, dst, links))
            st = ST_DUPLICATE;
         else if (sym && !add_link(dst, src, links))
            st = ST_DUPLICATE;
         hop.status = st;
         pending_hops = {pending_hops, hop};
         return;
      end
      if (!(cache_on && cache_held && cached_src == src))
         search_from(src);
      cached_src = src[NODE_BITS-1:0];
      cache_held = cache_on;
      if (src == dst) begin
         if (!link_present[src*NODES+src]) begin
            hop.status = ST_NO_ROUTE;
         end else begin
            hop.hop_from = src[NODE_BITS-1:0];
            hop.hop_to = src[NODE_BITS-1:0];
            hop.hop_links = link_cost[src*NODES+src];
            hop.total_links = {5'd0, link_cost[src*NODES+src]};
         end
         pending_hops = {pending_hops, hop};
         return;
      end
      if (path_dist[dst] == UNREACHED) begin
         hop.status = ST_NO_ROUTE;
         pending_hops = {pending_hops, hop};
         return;
      end
      total = 0;
      k = 0;
      v = dst;
      while (v != src && k < MAX_RESULTS) begin
         p = path_pred[v];
         c = link_present[p*NODES+v] ? link_cost[p*NODES+v] : '0;
         total += c;
         if (total > TOTAL_MAX)
            total = TOTAL_MAX;
         hop.status = ST_OK;
         hop.hop_from = p[NODE_BITS-1:0];
         hop.hop_to = v[NODE_BITS-1:0];
         hop.hop_links = c;
         hop.total_links = total[DIST_BITS-1:0];
         hop.last = (p == src || k == MAX_RESULTS - 1);
         pending_hops = {pending_hops, hop};
         k++;
         v = p;
      end
   endfunction

   // The task returns just after the rising edge that accepts the beat.
   task automatic send_request(logic mode, int src, int dst, int links, logic sym);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_src_node <= src[NODE_BITS-1:0];
      req_dst_node <= dst[NODE_BITS-1:0];
      req_link_count <= links[COST_BITS-1:0];
      req_symmetric <= sym;
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_route(mode, src, dst, links[COST_BITS-1:0], sym);
   endtask

   task automatic add_edge(int src, int dst, int links, logic sym);
      send_request(MODE_ADD, src, dst, links, sym);
   endtask

   task automatic query_route(int src, int dst);
      send_request(~MODE_ADD, src, dst, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_hops.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic set_cache(logic enable);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= enable;
      @(posedge clock);
      cache_on = enable;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed();
      set_cache(1'b0);
      add_edge(0, 31, 0, 1'b0);
      add_edge(0, 31, 7, 1'b0);
      add_edge(31, 0, 255, 1'b1);
      add_edge(5, 6, 255, 1'b1);
      add_edge(3, 3, 9, 1'b1);
      add_edge(31, 31, 255, 1'b0);
      query_route(3, 3);
      query_route(31, 31);
      query_route(4, 4);
      query_route(0, 31);
      query_route(31, 0);
      query_route(0, 5);
      query_route(6, 5);
      add_edge(31, 5, 1, 1'b0);
      add_edge(0, 6, 0, 1'b0);
      add_edge(0, 5, 1, 1'b0);
      query_route(0, 6);
      query_route(0, 5);
      query_route(5, 0);
      add_edge(10, 11, 4, 1'b0);
      add_edge(11, 12, 4, 1'b0);
      add_edge(10, 12, 8, 1'b0);
      query_route(10, 12);
   endtask

   task automatic test_long_chain();
      set_cache(1'b1);
      for (int i = 0; i < NODES - 1; i++)
         add_edge(i, i + 1, 255 - i, 1'b0);
      query_route(0, 31);
      query_route(0, 17);
      query_route(0, 0);
      query_route(31, 0);
      add_edge(1, 2, 3, 1'b1);
      query_route(0, 31);
   endtask

   task automatic test_random(int count, logic enable);
      int span;
      int src;
      int last_src;
      set_cache(enable);
      last_src = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         span = ($urandom_range(0, 3) == 0) ? NODES - 1 : 11;
         src = ($urandom_range(0, 2) == 0) ? last_src : $urandom_range(0, span);
         if ($urandom_range(0, 1) == 0)
            add_edge(src, $urandom_range(0, span), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
         else
            query_route(src, $urandom_range(0, span));
         last_src = src;
      end
      steady = 1'b0;
   endtask

   initial begin
      mismatches = 0;
      cycles = 0;
      steady = 1'b0;
      cache_on = 1'b0;
      cache_held = 1'b0;
      cached_src = '0;
      for (int i = 0; i < NODES*NODES; i++) begin
         link_present[i] = 1'b0;
         link_cost[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_chain();
      test_random(90, 1'b0);
      test_random(90, 1'b1);
      test_random(90, 1'b0);
      test_random(80, 1'b1);
      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && pending_hops.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

`default_nettype wire
